FILE: rtl/core/splc_pkg.sv
// splc_pkg: widths, config register codes, inter-stage beat structs and the
// elaboration-time builders for the log2 and exp2 interpolation tables.
// No dependencies; imported by every module of the compressor.
package splc_pkg;

    localparam int TABLE_INDEX_BITS = 8;
    localparam int TAB_SIZE         = (1 << TABLE_INDEX_BITS) + 1;
    localparam int TAB_ADDR_W       = TABLE_INDEX_BITS + 1;

    localparam int SAMPLE_W       = 24;
    localparam int SAMPLE_FRAC_W  = 12;
    localparam int FRAC_W         = SAMPLE_W - 1;
    localparam int EXP_POS_W      = 5;
    localparam int LOG_FRAC_W     = 16;
    localparam int LOG_R_W        = FRAC_W - TABLE_INDEX_BITS;
    localparam int EXP_R_W        = LOG_FRAC_W - TABLE_INDEX_BITS;
    localparam int LOG_ENT_W      = 17;
    localparam int EXP_ENT_W      = 32;
    localparam int LG_W           = 21;
    localparam int Q_W            = 22;
    localparam int IP_W           = Q_W - LOG_FRAC_W;
    localparam int GAIN_W         = 24;
    localparam int EXPONENT_W     = 17;
    localparam int RESULT_W       = 32;
    localparam int PROD_W         = GAIN_W + EXP_ENT_W;
    localparam int SH_W           = 7;
    localparam int POW_SHIFT_BASE = 34;
    localparam int CFG_INDEX_W    = 8;
    localparam int CFG_DATA_W     = 24;

    localparam logic [GAIN_W-1:0]     GAIN_RESET     = 24'd1310720;
    localparam logic [EXPONENT_W-1:0] EXPONENT_RESET = 17'd21627;

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GAIN     = 8'd0,
        CFG_EXPONENT = 8'd1
    } cfg_index_t;

    typedef logic [LOG_ENT_W-1:0] log_rom_t [TAB_SIZE];
    typedef logic [EXP_ENT_W-1:0] exp_rom_t [TAB_SIZE];

    // log2 domain beat, lg is Q16
    typedef struct packed {
        logic                   neg;
        logic                   zero;
        logic                   eob;
        logic signed [LG_W-1:0] lg;
    } log_beat_t;

    // power beat: p is the Q30 mantissa of the power, ip its integer exponent
    typedef struct packed {
        logic                   neg;
        logic                   zero;
        logic                   eob;
        logic signed [IP_W-1:0] ip;
        logic [EXP_ENT_W-1:0]   p;
    } pow_beat_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bit_v;
        int          k;
        n     = n_in;
        res   = '0;
        bit_v = 64'd1 << 62;
        for (k = 0; k < 32; k++)
        begin
            if (bit_v > n)
            begin
                bit_v = bit_v >> 2;
            end
        end
        for (k = 0; k < 32; k++)
        begin
            if (bit_v != '0)
            begin
                if (n >= res + bit_v)
                begin
                    n   = n - (res + bit_v);
                    res = (res >> 1) + bit_v;
                end
                else
                begin
                    res = res >> 1;
                end
                bit_v = bit_v >> 2;
            end
        end
        return res;
    endfunction

    // log2 of a Q30 value in [1,2], Q16 result, one bit per squaring
    function automatic logic [LOG_ENT_W-1:0] log2_q30(input logic [63:0] y_in);
        logic [63:0] y;
        logic [31:0] acc;
        int          k;
        y   = y_in;
        acc = '0;
        if (y >= (Q30_ONE << 1))
        begin
            acc = 32'd65536;
            y   = y >> 1;
        end
        for (k = 15; k >= 0; k--)
        begin
            y = (y * y) >> 30;
            if (y >= (Q30_ONE << 1))
            begin
                acc = acc | (32'd1 << k);
                y   = y >> 1;
            end
        end
        return acc[LOG_ENT_W-1:0];
    endfunction

    function automatic log_rom_t build_log_rom();
        log_rom_t rom;
        int       i;
        for (i = 0; i < TAB_SIZE; i++)
        begin
            rom[i] = log2_q30(Q30_ONE + (64'(i) << (30 - TABLE_INDEX_BITS)));
        end
        return rom;
    endfunction

    // exp2 entries from products of repeated square roots of two, truncated each step
    function automatic exp_rom_t build_exp_rom();
        exp_rom_t    rom;
        logic [63:0] roots [17];
        logic [63:0] acc;
        logic [15:0] frac;
        int          i;
        int          k;
        roots[0] = Q30_ONE << 1;
        for (k = 1; k <= 16; k++)
        begin
            roots[k] = isqrt64(roots[k-1] << 30);
        end
        for (i = 0; i < TAB_SIZE; i++)
        begin
            if (i == TAB_SIZE - 1)
            begin
                rom[i] = EXP_ENT_W'(Q30_ONE << 1);
            end
            else
            begin
                frac = 16'(i << EXP_R_W);
                acc  = Q30_ONE;
                for (k = 1; k <= 16; k++)
                begin
                    if (frac[16-k])
                    begin
                        acc = (acc * roots[k]) >> 30;
                    end
                end
                rom[i] = acc[EXP_ENT_W-1:0];
            end
        end
        return rom;
    endfunction

endpackage

FILE: rtl/core/signed_power_law_compressor_unit.sv
// Signed power-law compressor, top level: config registers and three pipeline sections.
// Pipeline: eight register stages from the sample input to the result output.
// Throughput: one sample per cycle unless result_ready stalls, set by the fully pipelined log, power and gain units.
// Stalls back up stage by stage; each stage takes a beat whenever it is empty or moving.
// Reset: clears all valid bits, gain to 20.0 and exponent to 0.33; no clearing pass.
// Uses splc_pkg, splc_log2, splc_exp2 and splc_scale.
module signed_power_law_compressor_unit
    import splc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       sample_valid,
    output logic                       sample_ready,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       end_of_block,
    output logic                       result_valid,
    input  logic                       result_ready,
    output logic signed [RESULT_W-1:0] result,
    output logic                       saturated,
    output logic                       end_of_block_out,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    logic [GAIN_W-1:0]     gain_reg, gain_next;
    logic [EXPONENT_W-1:0] exponent_reg, exponent_next;

    logic      log_valid, log_ready;
    log_beat_t log_beat;
    logic      pow_valid, pow_ready;
    pow_beat_t pow_beat;

    assign cfg_ready = 1'b1;

    // writes to an index beyond the list are dropped
    always_comb
    begin
        gain_next     = gain_reg;
        exponent_next = exponent_reg;
        if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_GAIN:     gain_next     = cfg_data[GAIN_W-1:0];
                CFG_EXPONENT: exponent_next = cfg_data[EXPONENT_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg     <= GAIN_RESET;
            exponent_reg <= EXPONENT_RESET;
        end
        else
        begin
            gain_reg     <= gain_next;
            exponent_reg <= exponent_next;
        end
    end

    splc_log2 u_log2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (sample_valid),
        .src_ready (sample_ready),
        .sample    (sample),
        .eob       (end_of_block),
        .dst_valid (log_valid),
        .dst_ready (log_ready),
        .dst_beat  (log_beat)
    );

    splc_exp2 u_exp2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .exponent  (exponent_reg),
        .src_valid (log_valid),
        .src_ready (log_ready),
        .src_beat  (log_beat),
        .dst_valid (pow_valid),
        .dst_ready (pow_ready),
        .dst_beat  (pow_beat)
    );

    splc_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .gain      (gain_reg),
        .src_valid (pow_valid),
        .src_ready (pow_ready),
        .src_beat  (pow_beat),
        .dst_valid (result_valid),
        .dst_ready (result_ready),
        .result    (result),
        .saturated (saturated),
        .eob       (end_of_block_out)
    );

endmodule

FILE: rtl/core/splc_log2.sv
// splc_log2: stages one to three, magnitude and leading-one search, normalise
// and table read, then interpolation into a signed Q16 log2. Uses splc_pkg.
module splc_log2
    import splc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       src_valid,
    output logic                       src_ready,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       eob,
    output logic                       dst_valid,
    input  logic                       dst_ready,
    output log_beat_t                  dst_beat
);

    localparam log_rom_t LOG_ROM = build_log_rom();

    logic ready1, ready2, ready3;

    // stage 1
    logic                 v1_reg;
    logic                 neg1_reg, neg1_next;
    logic                 zero1_reg, zero1_next;
    logic                 eob1_reg;
    logic [SAMPLE_W-1:0]  mag1_reg, mag1_next;
    logic [EXP_POS_W-1:0] epos1_reg, epos1_next;
    logic [SAMPLE_W-1:0]  raw;

    // stage 2
    logic                  v2_reg;
    logic                  neg2_reg, zero2_reg, eob2_reg;
    logic [EXP_POS_W-1:0]  epos2_reg;
    logic [LOG_ENT_W-1:0]  llo2_reg, llo2_next;
    logic [LOG_ENT_W-1:0]  ldiff2_reg, ldiff2_next;
    logic [LOG_R_W-1:0]    r2_reg, r2_next;
    logic [SAMPLE_W-1:0]   norm;
    logic [TAB_ADDR_W-1:0] addr_lo, addr_hi;

    // stage 3
    logic                         v3_reg;
    logic                         neg3_reg, zero3_reg, eob3_reg;
    logic signed [LG_W-1:0]       lg3_reg, lg3_next;
    logic [LOG_ENT_W+LOG_R_W-1:0] lprod;
    logic [LOG_ENT_W-1:0]         lf;
    logic signed [EXP_POS_W:0]    e_off;

    assign ready3    = !v3_reg || dst_ready;
    assign ready2    = !v2_reg || ready3;
    assign ready1    = !v1_reg || ready2;
    assign src_ready = ready1;

    always_comb
    begin
        raw        = sample;
        neg1_next  = raw[SAMPLE_W-1];
        mag1_next  = neg1_next ? (~raw + SAMPLE_W'(1)) : raw;
        zero1_next = (mag1_next == '0);
        epos1_next = '0;
        for (int i = 0; i < SAMPLE_W; i++)
        begin
            if (mag1_next[i])
            begin
                epos1_next = EXP_POS_W'(i);
            end
        end
    end

    always_comb
    begin
        norm        = mag1_reg << (EXP_POS_W'(FRAC_W) - epos1_reg);
        addr_lo     = {1'b0, norm[FRAC_W-1 -: TABLE_INDEX_BITS]};
        addr_hi     = addr_lo + TAB_ADDR_W'(1);
        r2_next     = norm[LOG_R_W-1:0];
        llo2_next   = LOG_ROM[addr_lo];
        ldiff2_next = LOG_ROM[addr_hi] - LOG_ROM[addr_lo];
    end

    always_comb
    begin
        lprod    = ldiff2_reg * r2_reg;
        lf       = llo2_reg + LOG_ENT_W'(lprod >> LOG_R_W);
        e_off    = $signed({1'b0, epos2_reg}) - (EXP_POS_W+1)'(SAMPLE_FRAC_W);
        lg3_next = (LG_W'(e_off) <<< LOG_FRAC_W) + LG_W'($signed({1'b0, lf}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= src_valid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1)
        begin
            neg1_reg  <= neg1_next;
            zero1_reg <= zero1_next;
            eob1_reg  <= eob;
            mag1_reg  <= mag1_next;
            epos1_reg <= epos1_next;
        end
        if (ready2)
        begin
            neg2_reg   <= neg1_reg;
            zero2_reg  <= zero1_reg;
            eob2_reg   <= eob1_reg;
            epos2_reg  <= epos1_reg;
            llo2_reg   <= llo2_next;
            ldiff2_reg <= ldiff2_next;
            r2_reg     <= r2_next;
        end
        if (ready3)
        begin
            neg3_reg  <= neg2_reg;
            zero3_reg <= zero2_reg;
            eob3_reg  <= eob2_reg;
            lg3_reg   <= lg3_next;
        end
    end

    assign dst_valid     = v3_reg;
    assign dst_beat.neg  = neg3_reg;
    assign dst_beat.zero = zero3_reg;
    assign dst_beat.eob  = eob3_reg;
    assign dst_beat.lg   = lg3_reg;

endmodule

FILE: rtl/core/splc_exp2.sv
// splc_exp2: stages four to six, scale the log by the exponent, split it and
// read the exp2 table, then interpolate the Q30 mantissa. Uses splc_pkg.
module splc_exp2
    import splc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [EXPONENT_W-1:0] exponent,
    input  logic                  src_valid,
    output logic                  src_ready,
    input  log_beat_t             src_beat,
    output logic                  dst_valid,
    input  logic                  dst_ready,
    output pow_beat_t             dst_beat
);

    localparam exp_rom_t EXP_ROM = build_exp_rom();

    logic ready4, ready5, ready6;

    // stage 4
    logic                           v4_reg;
    logic                           neg4_reg, zero4_reg, eob4_reg;
    logic signed [Q_W-1:0]          q4_reg, q4_next;
    logic signed [LG_W+EXPONENT_W:0] qprod;

    // stage 5
    logic                  v5_reg;
    logic                  neg5_reg, zero5_reg, eob5_reg;
    logic signed [IP_W-1:0] ip5_reg;
    logic [EXP_ENT_W-1:0]  elo5_reg, elo5_next;
    logic [EXP_ENT_W-1:0]  ediff5_reg, ediff5_next;
    logic [EXP_R_W-1:0]    r5_reg, r5_next;
    logic [LOG_FRAC_W-1:0] u;
    logic [TAB_ADDR_W-1:0] addr_lo, addr_hi;

    // stage 6
    logic                          v6_reg;
    logic                          neg6_reg, zero6_reg, eob6_reg;
    logic signed [IP_W-1:0]        ip6_reg;
    logic [EXP_ENT_W-1:0]          p6_reg, p6_next;
    logic [EXP_ENT_W+EXP_R_W-1:0]  eprod;

    assign ready6    = !v6_reg || dst_ready;
    assign ready5    = !v5_reg || ready6;
    assign ready4    = !v4_reg || ready5;
    assign src_ready = ready4;

    // arithmetic shift gives the floor for negative logs
    always_comb
    begin
        qprod   = src_beat.lg * $signed({1'b0, exponent});
        q4_next = Q_W'(qprod >>> LOG_FRAC_W);
    end

    always_comb
    begin
        u           = q4_reg[LOG_FRAC_W-1:0];
        addr_lo     = {1'b0, u[LOG_FRAC_W-1 -: TABLE_INDEX_BITS]};
        addr_hi     = addr_lo + TAB_ADDR_W'(1);
        r5_next     = u[EXP_R_W-1:0];
        elo5_next   = EXP_ROM[addr_lo];
        ediff5_next = EXP_ROM[addr_hi] - EXP_ROM[addr_lo];
    end

    always_comb
    begin
        eprod   = ediff5_reg * r5_reg;
        p6_next = elo5_reg + EXP_ENT_W'(eprod >> EXP_R_W);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (ready4)
            begin
                v4_reg <= src_valid;
            end
            if (ready5)
            begin
                v5_reg <= v4_reg;
            end
            if (ready6)
            begin
                v6_reg <= v5_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready4)
        begin
            neg4_reg  <= src_beat.neg;
            zero4_reg <= src_beat.zero;
            eob4_reg  <= src_beat.eob;
            q4_reg    <= q4_next;
        end
        if (ready5)
        begin
            neg5_reg   <= neg4_reg;
            zero5_reg  <= zero4_reg;
            eob5_reg   <= eob4_reg;
            ip5_reg    <= q4_reg[Q_W-1:LOG_FRAC_W];
            elo5_reg   <= elo5_next;
            ediff5_reg <= ediff5_next;
            r5_reg     <= r5_next;
        end
        if (ready6)
        begin
            neg6_reg  <= neg5_reg;
            zero6_reg <= zero5_reg;
            eob6_reg  <= eob5_reg;
            ip6_reg   <= ip5_reg;
            p6_reg    <= p6_next;
        end
    end

    assign dst_valid     = v6_reg;
    assign dst_beat.neg  = neg6_reg;
    assign dst_beat.zero = zero6_reg;
    assign dst_beat.eob  = eob6_reg;
    assign dst_beat.ip   = ip6_reg;
    assign dst_beat.p    = p6_reg;

endmodule

FILE: rtl/core/splc_scale.sv
// splc_scale: stages seven and eight, gain multiply, shift by the power's
// integer part, saturate, restore sign; stage eight is the output register.
// Uses splc_pkg.
module splc_scale
    import splc_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [GAIN_W-1:0]          gain,
    input  logic                       src_valid,
    output logic                       src_ready,
    input  pow_beat_t                  src_beat,
    output logic                       dst_valid,
    input  logic                       dst_ready,
    output logic signed [RESULT_W-1:0] result,
    output logic                       saturated,
    output logic                       eob
);

    logic ready7, ready8;

    // stage 7
    logic                   v7_reg;
    logic                   neg7_reg, zero7_reg, eob7_reg;
    logic signed [IP_W-1:0] ip7_reg;
    logic [PROD_W-1:0]      prod7_reg, prod7_next;

    // stage 8
    logic                v8_reg;
    logic                neg8_reg, zero8_reg, eob8_reg;
    logic                sat8_reg, sat8_next;
    logic [RESULT_W-1:0] res8_reg, res8_next;
    logic [SH_W-1:0]     sh;
    logic [PROD_W-1:0]   absv;
    logic [PROD_W-1:0]   lim;
    logic [RESULT_W-1:0] mag;

    assign ready8    = !v8_reg || dst_ready;
    assign ready7    = !v7_reg || ready8;
    assign src_ready = ready7;

    always_comb
    begin
        prod7_next = gain * src_beat.p;
    end

    // shift right by 34 - ip, always between 11 and 58 places
    always_comb
    begin
        sh        = SH_W'(POW_SHIFT_BASE) - SH_W'(ip7_reg);
        absv      = prod7_reg >> sh;
        lim       = neg7_reg ? (PROD_W'(1) << (RESULT_W - 1))
                             : ((PROD_W'(1) << (RESULT_W - 1)) - PROD_W'(1));
        sat8_next = !zero7_reg && (absv > lim);
        mag       = sat8_next ? lim[RESULT_W-1:0] : absv[RESULT_W-1:0];
        if (zero7_reg)
        begin
            res8_next = '0;
        end
        else if (neg7_reg)
        begin
            res8_next = ~mag + RESULT_W'(1);
        end
        else
        begin
            res8_next = mag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
        end
        else
        begin
            if (ready7)
            begin
                v7_reg <= src_valid;
            end
            if (ready8)
            begin
                v8_reg <= v7_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready7)
        begin
            neg7_reg  <= src_beat.neg;
            zero7_reg <= src_beat.zero;
            eob7_reg  <= src_beat.eob;
            ip7_reg   <= src_beat.ip;
            prod7_reg <= prod7_next;
        end
        if (ready8)
        begin
            neg8_reg  <= neg7_reg;
            zero8_reg <= zero7_reg;
            eob8_reg  <= eob7_reg;
            sat8_reg  <= sat8_next;
            res8_reg  <= res8_next;
        end
    end

    assign dst_valid = v8_reg;
    assign result    = res8_reg;
    assign saturated = sat8_reg;
    assign eob       = eob8_reg;

    // zero sample always gives a clean zero
    assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && zero8_reg |-> result == '0 && !saturated)
        else $error("zero sample gave non-zero result");

    // clipped results sit exactly on a range limit of the right sign
    assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && saturated |->
            (neg8_reg && result == {1'b1, {(RESULT_W-1){1'b0}}}) ||
            (!neg8_reg && result == {1'b0, {(RESULT_W-1){1'b1}}}))
        else $error("saturated result off the range limit");

    // sign of a non-zero result follows the sample
    assert property (@(posedge clk) disable iff (!rst_n)
        dst_valid && !zero8_reg && result != '0 |-> result[RESULT_W-1] == neg8_reg)
        else $error("result sign differs from sample sign");

    // an empty output register never holds off the stage ahead of it
    assert property (@(posedge clk) disable iff (!rst_n)
        !dst_valid |-> src_ready)
        else $error("stage stalled with output register empty");

endmodule

FILE: test/signed_power_law_compressor_unit_tb.sv
// Testbench for signed_power_law_compressor_unit: directed and random samples under many
// gain/exponent settings, checked against a table-based power-law predictor kept here.
// Depends on splc_pkg and the compressor RTL only.
`timescale 1ns / 100ps

module signed_power_law_compressor_unit_tb
    import splc_pkg::*;
();

    localparam int CLK_HALF     = 4;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_PHASES    = 8;
    localparam int SAMPLES_PER_PHASE = 240;

    localparam int unsigned FIRST_UNUSED_INDEX = CFG_EXPONENT + 1;
    localparam int unsigned LAST_INDEX         = (1 << CFG_INDEX_W) - 1;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_ONE = SAMPLE_W'(1 << SAMPLE_FRAC_W);
    localparam logic [GAIN_W-1:0]          GAIN_MAX     = '1;
    localparam logic [EXPONENT_W-1:0]      EXPONENT_MAX = '1;

    typedef struct {
        logic signed [RESULT_W-1:0] value;
        logic                       sat;
        logic                       eob;
    } compressed_t;

    typedef enum {READY_ALWAYS, READY_COIN, READY_PERIODIC, READY_BURSTY} ready_pattern_t;

    class power_law_scoreboard;
        logic [GAIN_W-1:0]     gain;
        logic [EXPONENT_W-1:0] exponent;
        longint                log2_table [TAB_SIZE];
        longint                exp2_table [TAB_SIZE];
        compressed_t           pending_results [$];
        int                    errors;
        int                    checked;
        int                    clipped;

        function new();
            gain     = GAIN_RESET;
            exponent = EXPONENT_RESET;
            errors   = 0;
            checked  = 0;
            clipped  = 0;
            build_tables();
        endfunction

        function longint floor_sqrt(longint n);
            longint res;
            longint t;
            int     b;
            res = 0;
            for (b = 31; b >= 0; b--)
            begin
                t = res | (longint'(1) << b);
                if (t * t <= n)
                    res = t;
            end
            return res;
        endfunction

        function void build_tables();
            longint                roots [17];
            longint                y;
            longint                acc;
            logic [LOG_FRAC_W-1:0] frac;
            int                    i;
            int                    k;
            roots[0] = longint'(1) << 31;
            for (k = 1; k <= LOG_FRAC_W; k++)
                roots[k] = floor_sqrt(roots[k-1] << 30);
            for (i = 0; i < TAB_SIZE; i++)
            begin
                // log2 by repeated squaring, one result bit per square
                y   = (longint'(1) << 30) + (longint'(i) << (30 - TABLE_INDEX_BITS));
                acc = 0;
                if (y >= (longint'(1) << 31))
                begin
                    acc = longint'(1) << LOG_FRAC_W;
                    y   = y >> 1;
                end
                for (k = LOG_FRAC_W - 1; k >= 0; k--)
                begin
                    y = (y * y) >> 30;
                    if (y >= (longint'(1) << 31))
                    begin
                        acc = acc | (longint'(1) << k);
                        y   = y >> 1;
                    end
                end
                log2_table[i] = acc;

                // exp2 as a product of root-of-two powers, truncated at each step
                if (i == TAB_SIZE - 1)
                begin
                    exp2_table[i] = longint'(1) << 31;
                end
                else
                begin
                    frac = LOG_FRAC_W'(i << EXP_R_W);
                    acc  = longint'(1) << 30;
                    for (k = 1; k <= LOG_FRAC_W; k++)
                    begin
                        if (frac[LOG_FRAC_W-k])
                            acc = (acc * roots[k]) >> 30;
                    end
                    exp2_table[i] = acc;
                end
            end
        endfunction

        function void apply_config(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                CFG_GAIN:     gain     = data[GAIN_W-1:0];
                CFG_EXPONENT: exponent = data[EXPONENT_W-1:0];
                default:      ;
            endcase
        endfunction

        function compressed_t compress(logic signed [SAMPLE_W-1:0] x, logic eob);
            compressed_t       c;
            logic [SAMPLE_W:0] mag;
            logic [SAMPLE_W:0] norm;
            int                top;
            int                j;
            int                s;
            longint            r;
            longint            lg;
            longint            q;
            longint            ip;
            longint            u;
            longint            p;
            longint            prod;
            longint            absv;
            longint            lim;
            logic              clip;
            c.value = '0;
            c.sat   = 1'b0;
            c.eob   = eob;
            mag = x[SAMPLE_W-1] ? (SAMPLE_W+1)'((1 << SAMPLE_W) - {1'b0, x}) : {1'b0, x};
            if (mag == 0 || gain == 0)
                return c;

            top = FRAC_W;
            while (!mag[top])
                top--;
            norm = mag << (FRAC_W - top);
            j    = int'(norm[FRAC_W-1:LOG_R_W]);
            r    = longint'(norm[LOG_R_W-1:0]);
            lg   = longint'(top - SAMPLE_FRAC_W) * (longint'(1) << LOG_FRAC_W) + log2_table[j]
                   + (((log2_table[j+1] - log2_table[j]) * r) >> LOG_R_W);

            // floor on both shifts, so negative logs round down
            q  = (lg * longint'(exponent)) >>> LOG_FRAC_W;
            ip = q >>> LOG_FRAC_W;
            u  = q & ((longint'(1) << LOG_FRAC_W) - 1);

            j = int'(u >> EXP_R_W);
            r = u & ((longint'(1) << EXP_R_W) - 1);
            p = exp2_table[j] + (((exp2_table[j+1] - exp2_table[j]) * r) >> EXP_R_W);

            prod = longint'(gain) * p;
            s    = int'(ip) - POW_SHIFT_BASE;
            lim  = x[SAMPLE_W-1] ? (longint'(1) << 31) : (longint'(1) << 31) - 1;
            clip = 1'b0;
            absv = 0;
            if (s >= 32)
            begin
                clip = 1'b1;
            end
            else if (s > 0)
            begin
                if ((prod >> (63 - s)) != 0)
                    clip = 1'b1;
                else
                    absv = prod << s;
            end
            else if (s > -64)
            begin
                absv = prod >> (-s);
            end
            if (clip || absv > lim)
            begin
                clip = 1'b1;
                absv = lim;
            end
            c.value = x[SAMPLE_W-1] ? RESULT_W'(-absv) : RESULT_W'(absv);
            c.sat   = clip;
            return c;
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] x, logic eob);
            pending_results.push_back(compress(x, eob));
        endfunction

        function void check_result(logic signed [RESULT_W-1:0] value, logic sat, logic eob);
            compressed_t want;
            if (pending_results.size() == 0)
            begin
                $error("result beat %0d arrived with no sample pending", value);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (sat)
                clipped++;
            if (value !== want.value)
            begin
                $error("result: expected %0d, got %0d", want.value, value);
                errors++;
            end
            if (sat !== want.sat)
            begin
                $error("saturated: expected %0b, got %0b", want.sat, sat);
                errors++;
            end
            if (eob !== want.eob)
            begin
                $error("end_of_block_out: expected %0b, got %0b", want.eob, eob);
                errors++;
            end
        endfunction

        function int pending_count();
            return pending_results.size();
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       sample_valid;
    logic                       sample_ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       end_of_block;
    logic                       result_valid;
    logic                       result_ready = 1'b0;
    logic signed [RESULT_W-1:0] result;
    logic                       saturated;
    logic                       end_of_block_out;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_INDEX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    power_law_scoreboard sb = new();

    int             burst_left;
    int             settings_used;
    ready_pattern_t ready_pattern = READY_ALWAYS;
    int             pattern_left  = 0;
    int             stall_run     = 0;

    signed_power_law_compressor_unit i_dut (.*);

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // receiver back-pressure, switching between a few patterns
    always @(negedge clk)
    begin
        if (pattern_left == 0)
        begin
            ready_pattern = ready_pattern_t'($urandom_range(0, 3));
            pattern_left  = $urandom_range(16, 128);
        end
        pattern_left--;
        case (ready_pattern)
            READY_ALWAYS:   result_ready = 1'b1;
            READY_COIN:     result_ready = ($urandom_range(0, 1) == 1);
            READY_PERIODIC: result_ready = (pattern_left % 5) != 0;
            default:
            begin
                if (stall_run > 0)
                begin
                    result_ready = 1'b0;
                    stall_run--;
                end
                else
                begin
                    result_ready = 1'b1;
                    if ($urandom_range(0, 15) == 0)
                        stall_run = $urandom_range(4, 16);
                end
            end
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_result(result, saturated, end_of_block_out);
    end

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x, input logic eob);
        if (burst_left == 0)
        begin
            @(negedge clk);
            sample_valid = 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        @(negedge clk);
        sample_valid = 1'b1;
        sample       = x;
        end_of_block = eob;
        do
            @(posedge clk);
        while (!sample_ready);
        sb.note_sample(x, eob);
        burst_left--;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = index;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.apply_config(index, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // every sample yields a result, so an empty queue means an empty pipeline
    task automatic wait_drained();
        @(negedge clk);
        sample_valid = 1'b0;
        while (sb.pending_count() != 0)
            @(posedge clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        int unsigned                w;
        logic signed [SAMPLE_W-1:0] x;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0:       x = SAMPLE_MAX;
                    1:       x = SAMPLE_MIN;
                    2:       x = '0;
                    3:       x = SAMPLE_W'(1);
                    default: x = '1;
                endcase
            end
            1, 2, 3, 4: x = SAMPLE_W'($urandom);
            default:
            begin
                // magnitudes spread evenly over the octaves
                w = $urandom_range(0, SAMPLE_W - 1);
                x = SAMPLE_W'($urandom_range(0, (1 << w) - 1));
                if ($urandom_range(0, 1) == 1)
                    x = -x;
            end
        endcase
        return x;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return CFG_DATA_W'(GAIN_MAX);
            2:       return CFG_DATA_W'(1);
            3:       return CFG_DATA_W'(GAIN_RESET);
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_exponent();
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'($urandom);
        case ($urandom_range(0, 6))
            0:       data[EXPONENT_W-1:0] = '0;
            1:       data[EXPONENT_W-1:0] = EXPONENT_MAX;
            2:       data[EXPONENT_W-1:0] = EXPONENT_W'(1 << LOG_FRAC_W);
            3:       data[EXPONENT_W-1:0] = EXPONENT_W'(1 << (LOG_FRAC_W - 1));
            4:       data[EXPONENT_W-1:0] = EXPONENT_RESET;
            default: ;
        endcase
        return data;
    endfunction

    initial
    begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        int phase;
        rst_n         = 1'b0;
        sample_valid  = 1'b0;
        sample        = '0;
        end_of_block  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        burst_left    = 0;
        settings_used = 1;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: 20.0 gain, 0.33 exponent
        send_sample('0, 1'b0);
        send_sample(SAMPLE_W'(1), 1'b0);
        send_sample(SAMPLE_W'(-1), 1'b0);
        send_sample(SAMPLE_ONE, 1'b0);
        send_sample(-SAMPLE_ONE, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample(24'h555555, 1'b0);
        send_sample(24'haaaaaa, 1'b1);
        send_sample(SAMPLE_W'(2), 1'b0);

        // zero gain mutes everything
        wait_drained();
        write_reg(CFG_GAIN, '0);
        settings_used++;
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);

        // zero exponent passes the gain straight through; upper data bits fall outside
        wait_drained();
        write_reg(CFG_GAIN, CFG_DATA_W'(GAIN_MAX));
        write_reg(CFG_EXPONENT, {{(CFG_DATA_W-EXPONENT_W){1'b1}}, {EXPONENT_W{1'b0}}});
        settings_used++;
        send_sample(SAMPLE_ONE, 1'b0);
        send_sample(SAMPLE_W'(-1), 1'b0);
        send_sample('0, 1'b1);

        // largest gain and exponent push both signs into the rails
        wait_drained();
        write_reg(CFG_EXPONENT, CFG_DATA_W'(EXPONENT_MAX));
        settings_used++;
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_ONE << 10, 1'b0);
        send_sample(-(SAMPLE_ONE << 10), 1'b1);

        // write beyond the register list must leave the settings alone
        wait_drained();
        write_reg(CFG_INDEX_W'(FIRST_UNUSED_INDEX), '0);
        send_sample(SAMPLE_ONE, 1'b0);

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_drained();
            write_reg(CFG_EXPONENT, pick_exponent());
            write_reg(CFG_GAIN, pick_gain());
            if ($urandom_range(0, 1) == 1)
                write_reg(CFG_INDEX_W'($urandom_range(FIRST_UNUSED_INDEX, LAST_INDEX)),
                          CFG_DATA_W'($urandom));
            settings_used++;
            repeat (SAMPLES_PER_PHASE)
                send_sample(random_sample(), $urandom_range(0, 7) == 0);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d compressed samples over %0d gain/exponent settings",
                 sb.checked, settings_used);
        $display("%0d of them clipped to the output range", sb.clipped);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/splc_pkg.sv
rtl/core/splc_log2.sv
rtl/core/splc_exp2.sv
rtl/core/splc_scale.sv
rtl/core/signed_power_law_compressor_unit.sv
test/signed_power_law_compressor_unit_tb.sv
